// ----- design/esap_pkg.sv -----
// esap_pkg: shared constants, types and register codes of the encoder speed meter
// no dependencies; compiled before every other design file
package esap_pkg;

  localparam int CHANNELS    = 2;
  localparam int TIMER_BITS  = 32;
  localparam int CAP_W       = 32;
  localparam int SCALE_W     = 48;
  localparam int SPEED_W     = 31;
  localparam int IDLE_W      = 16;
  localparam int RATIO_SHIFT = 3;                      // divide-by-eight capture prescale
  localparam int NUM_W       = SCALE_W + RATIO_SHIFT;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SCALE_W;

  localparam logic [SCALE_W-1:0]  SCALE_RST     = '0;
  localparam logic [SPEED_W-1:0]  HIGH_THR_RST  = '1;
  localparam logic [SPEED_W-1:0]  LOW_THR_RST   = '0;
  localparam logic [IDLE_W-1:0]   MAX_IDLE_RST  = IDLE_W'(100);
  localparam logic [CHANNELS-1:0] DIR_INV_RST   = CHANNELS'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE    = 3'd0,
    CFG_HIGH_THRESHOLD = 3'd1,
    CFG_LOW_THRESHOLD  = 3'd2,
    CFG_MAX_IDLE_TICKS = 3'd3,
    CFG_DIR_INVERT     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_QUERY   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } esap_state_e;

  typedef struct packed {
    logic             op;
    logic             channel;
    logic [CAP_W-1:0] cap_stamp;
    logic             other_phase;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_out;
    logic               divider_eight;
    logic               divider_changed;
    logic               timed_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  speed_scale;
    logic [SPEED_W-1:0]  high_threshold;
    logic [SPEED_W-1:0]  low_threshold;
    logic [IDLE_W-1:0]   max_idle_ticks;
    logic [CHANNELS-1:0] dir_invert;
  } cfg_regs_t;

endpackage

// ----- design/esap_if.sv -----
// esap_if: valid/ready channel interfaces for input words, result words and register writes
// depends on esap_pkg for the payload types
interface esap_in_if;
  import esap_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esap_out_if;
  import esap_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esap_cfg_if;
  import esap_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/esap_cfg.sv -----
// esap_cfg: configuration register file written through the register channel
// depends on esap_pkg and esap_if
module esap_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  esap_cfg_if.sink             cfg_i,
  output esap_pkg::cfg_regs_t  regs_o
);
  import esap_pkg::*;

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.speed_scale    <= SCALE_RST;
      regs_q.high_threshold <= HIGH_THR_RST;
      regs_q.low_threshold  <= LOW_THR_RST;
      regs_q.max_idle_ticks <= MAX_IDLE_RST;
      regs_q.dir_invert     <= DIR_INV_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.index))
        CFG_SPEED_SCALE:    regs_q.speed_scale    <= cfg_i.data.wdata[SCALE_W-1:0];
        CFG_HIGH_THRESHOLD: regs_q.high_threshold <= cfg_i.data.wdata[SPEED_W-1:0];
        CFG_LOW_THRESHOLD:  regs_q.low_threshold  <= cfg_i.data.wdata[SPEED_W-1:0];
        CFG_MAX_IDLE_TICKS: regs_q.max_idle_ticks <= cfg_i.data.wdata[IDLE_W-1:0];
        CFG_DIR_INVERT:     regs_q.dir_invert     <= cfg_i.data.wdata[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/esap_div.sv -----
// esap_div: bit-serial restoring divider, one quotient bit per cycle, saturating quotient
// depends on esap_pkg
module esap_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [esap_pkg::NUM_W-1:0]      num_i,
  input  logic [esap_pkg::TIMER_BITS-1:0] den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [esap_pkg::SPEED_W-1:0]    quot_o
);
  import esap_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NUM_W-1:0]      num_q;
  logic [TIMER_BITS-1:0] den_q;
  logic [TIMER_BITS:0]   rem_q, rem_sh, rem_d;
  logic [SPEED_W-1:0]    quot_q;
  logic                  ovf_q;
  logic                  ge;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q[TIMER_BITS-1:0], num_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[SPEED_W-2:0], ge};
      // a one leaving the top means the quotient no longer fits
      ovf_q  <= ovf_q | quot_q[SPEED_W-1];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = ovf_q ? {SPEED_W{1'b1}} : quot_q;

endmodule

// ----- design/encoder_speed_adaptive_prescale_top.sv -----
// encoder_speed_adaptive_prescale_top: two-channel encoder speed meter with adaptive prescale
// depends on esap_pkg, esap_if, esap_cfg and esap_div
//
//   port    dir   modport  word
//   in_i    in    sink     op, channel, cap_stamp, other_phase
//   out_o   out   source   speed_out, divider_eight, divider_changed, timed_out
//   cfg_i   in    sink     register index, write data
//
// a capture that needs a new speed passes from accept through S_EXEC, which forms the
// timer difference and starts the bit-serial divider, S_DIV, which waits for its quotient,
// and S_FIN, which commits; queries, zero differences and skipped captures skip S_DIV
// reset clears all channel state and loads the register defaults; no clearing pass
// the result waits in the output register; the next word is taken meanwhile and is
// held before its commit while that register is still full
module encoder_speed_adaptive_prescale_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  esap_in_if.sink    in_i,
  esap_out_if.source out_o,
  esap_cfg_if.sink   cfg_i
);
  import esap_pkg::*;

  cfg_regs_t   regs;
  esap_state_e state_q, state_d;
  in_item_t    item_q;

  logic [TIMER_BITS-1:0] prev_q [CHANNELS];
  logic [SPEED_W-1:0]    mag_q  [CHANNELS];
  logic [IDLE_W-1:0]     idle_q [CHANNELS];
  logic [CHANNELS-1:0]   div8_q, skip_q, dir_q;

  out_item_t out_q, res;
  logic      out_valid_q;
  logic      slot_free;

  logic                  div_start, div_busy, div_done, commit;
  logic [SPEED_W-1:0]    quot;
  logic [NUM_W-1:0]      num;
  logic                  ch, ch_ok;
  logic [TIMER_BITS-1:0] cap_t, diff;
  logic                  diff_nz, needs_div;

  logic [SPEED_W-1:0] mag_n;
  logic [IDLE_W-1:0]  idle_n;
  logic               div8_n, skip_n, dir_n;

  esap_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  assign ch        = item_q.channel;
  assign ch_ok     = int'(item_q.channel) < CHANNELS;
  assign cap_t     = item_q.cap_stamp[TIMER_BITS-1:0];
  assign diff      = cap_t - prev_q[ch];
  assign diff_nz   = diff != '0;
  assign needs_div = ch_ok && (item_q.op == OP_CAPTURE) && diff_nz && !skip_q[ch];
  assign num       = div8_q[ch] ? {regs.speed_scale, {RATIO_SHIFT{1'b0}}}
                                : {{RATIO_SHIFT{1'b0}}, regs.speed_scale};

  esap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (diff),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (needs_div) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result word and next channel state for the word being committed
  always_comb begin
    res    = '0;
    mag_n  = mag_q[ch];
    idle_n = idle_q[ch];
    div8_n = div8_q[ch];
    skip_n = skip_q[ch];
    dir_n  = dir_q[ch];
    if (ch_ok) begin
      if (item_q.op == OP_CAPTURE) begin
        idle_n = '0;
        if (diff_nz) begin
          if (skip_q[ch]) begin
            skip_n = 1'b0;
          end else begin
            mag_n = quot;
          end
          dir_n = item_q.other_phase ^ regs.dir_invert[ch];
          if (mag_n > regs.high_threshold && !div8_q[ch]) begin
            div8_n              = 1'b1;
            skip_n              = 1'b1;
            res.divider_changed = 1'b1;
          end else if (mag_n < regs.low_threshold && div8_q[ch]) begin
            div8_n              = 1'b0;
            skip_n              = 1'b1;
            res.divider_changed = 1'b1;
          end
        end
      end else if (idle_q[ch] < regs.max_idle_ticks) begin
        idle_n        = idle_q[ch] + 1'b1;
        res.speed_out = dir_q[ch] ? signed'({1'b0, mag_q[ch]})
                                  : signed'(32'd0 - {1'b0, mag_q[ch]});
      end else begin
        mag_n         = '0;
        res.timed_out = 1'b1;
      end
      res.divider_eight = div8_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) item_q <= in_i.data;
    if (commit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev_q[c] <= '0;
        mag_q[c]  <= '0;
        idle_q[c] <= '0;
      end
      div8_q <= '0;
      skip_q <= '0;
      dir_q  <= '0;
    end else if (commit && ch_ok) begin
      if (item_q.op == OP_CAPTURE) prev_q[ch] <= cap_t;
      mag_q[ch]  <= mag_n;
      idle_q[ch] <= idle_n;
      div8_q[ch] <= div8_n;
      skip_q[ch] <= skip_n;
      dir_q[ch]  <= dir_n;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_done_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside divide state");

  a_timeout_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.timed_out |->
      out_o.data.speed_out == 32'sd0 && !out_o.data.divider_changed)
    else $error("timed-out word carries speed or divider change");

  a_change_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.divider_changed |-> out_o.data.speed_out == 32'sd0)
    else $error("capture word carries nonzero speed");

endmodule
